>>> rtl/qte_pkg.sv
// Shared types, widths and constants for the quaternion to Euler angle converter.
// Depends on nothing; every other file imports it.
package qte_pkg;

    // Field widths of the input and result beats.
    localparam int QUAT_WIDTH  = 16;
    localparam int ANGLE_WIDTH = 16;

    // Inputs wider than 30 bits are floored down to 30 before the products.
    localparam int QSH    = (QUAT_WIDTH > 30) ? (QUAT_WIDTH - 30) : 0;
    localparam int QIN_W  = QUAT_WIDTH - QSH;
    localparam int PROD_W = 2 * QIN_W;
    localparam int SUM_W  = PROD_W + 3;
    localparam int FRAC2  = 2 * (QIN_W - 2);

    // Arcsine argument in Q30 and its scaling from the product format.
    localparam int T_W     = 32;
    localparam int T_SH_UP = (FRAC2 < 30) ? (30 - FRAC2) : 0;
    localparam int T_SH_DN = (FRAC2 >= 30) ? (FRAC2 - 30) : 0;
    localparam int WIDE_W  = 64;

    // Square root of 1 - t^2 in Q30.
    localparam int SQ_W        = 62;
    localparam int SQRT_STEPS  = 31;
    localparam int ROOT_W      = 31;

    // Arctangent unit: operand width, normalized magnitude, CORDIC widths.
    localparam int OP_W         = 64;
    localparam int POS_W        = $clog2(OP_W);
    localparam int NORM_MSB     = 39;
    localparam int CW           = 43;
    localparam int ZW           = 34;
    localparam int CORDIC_STEPS = 30;
    localparam int ATAN_LAT     = CORDIC_STEPS + 3;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // atan(2^-i) in units where pi is 2^31.
    localparam logic [31:0] ATAN_TABLE [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic signed [QUAT_WIDTH-1:0] quat_w;
        logic signed [QUAT_WIDTH-1:0] quat_x;
        logic signed [QUAT_WIDTH-1:0] quat_y;
        logic signed [QUAT_WIDTH-1:0] quat_z;
    } quat_in_t;

    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] roll_angle;
        logic signed [ANGLE_WIDTH-1:0] pitch_angle;
        logic signed [ANGLE_WIDTH-1:0] yaw_angle;
        logic                          pitch_clamped;
    } euler_out_t;

    // Operands that ride along with the square root.
    typedef struct packed {
        logic signed [SUM_W-1:0] roll_y;
        logic signed [SUM_W-1:0] roll_x;
        logic signed [SUM_W-1:0] yaw_y;
        logic signed [SUM_W-1:0] yaw_x;
        logic signed [T_W-1:0]   t;
        logic                    clamp;
    } qte_side_t;

    // One queue entry: side operands plus the square root radicand.
    typedef struct packed {
        qte_side_t       side;
        logic [SQ_W-1:0] rad;
    } qte_item_t;

    // Occupancy of the front pipeline stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } qte_front_status_t;

endpackage

>>> rtl/quaternion_to_euler.sv
// Quaternion (w, x, y, z) to roll, pitch and yaw angles, fully pipelined.
// A beat passes the front stages, the queue, the 31-stage square root and the 33-stage
// arctangent pipelines, then the result register. Throughput: one beat every cycle while busy is low.
// The receiver cannot stall; busy only rises if the front-to-back queue could overflow.
// Reset (rst_n low, asynchronous) clears all valid bits and the queue; no result is lost
// after reset is released. Depends on qte_pkg, qte_front, qte_queue and qte_back.
module quaternion_to_euler
    import qte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  quat_in_t   quat,
    output logic       done,
    output euler_out_t euler
);

    localparam int OCC_W = QCNT_W + 1;

    logic              take;
    logic              push;
    qte_item_t         front_item;
    qte_front_status_t front_status;
    logic [QCNT_W-1:0] q_count;
    logic              q_valid;
    qte_item_t         q_item;
    logic [OCC_W-1:0]  occupancy;

    // Hold off new beats when queued plus in-flight beats could fill the queue.
    assign occupancy = OCC_W'(q_count) + OCC_W'(front_status.s1) + OCC_W'(front_status.s2)
                     + OCC_W'(front_status.s3);
    assign busy = (occupancy >= OCC_W'(QUEUE_DEPTH));
    assign take = start & ~busy;

    qte_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .quat   (quat),
        .push   (push),
        .item   (front_item),
        .status (front_status)
    );

    qte_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_item  (front_item),
        .count    (q_count),
        .rd_valid (q_valid),
        .rd_item  (q_item)
    );

    qte_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_item  (q_item),
        .done     (done),
        .euler    (euler)
    );

endmodule

>>> rtl/qte_front.sv
// Front end: takes quaternion beats, forms the products and sums, clamps the arcsine
// argument and prepares the square root radicand. Depends on qte_pkg.
module qte_front
    import qte_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  quat_in_t          quat,
    output logic              push,
    output qte_item_t         item,
    output qte_front_status_t status
);

    localparam logic signed [SUM_W-1:0] ONE_S = SUM_W'(1) <<< FRAC2;
    localparam logic signed [WIDE_W-1:0] RAD_ONE = WIDE_W'(1) <<< 60;

    logic signed [QIN_W-1:0]  w_s, x_s, y_s, z_s;
    logic signed [PROD_W-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PROD_W-1:0] wx_reg, yz_reg, wz_reg, xy_reg, xz_reg, wy_reg;
    logic                     s1_valid_reg, s2_valid_reg, s3_valid_reg;
    qte_side_t                s2_side_reg, s2_side_next;
    qte_item_t                s3_item_reg, s3_item_next;
    logic signed [SUM_W-1:0]  s_sum;
    logic signed [WIDE_W-1:0] s_wide;
    logic signed [WIDE_W-1:0] tt;

    // Floor the inputs down to the product width.
    assign w_s = QIN_W'(quat.quat_w >>> QSH);
    assign x_s = QIN_W'(quat.quat_x >>> QSH);
    assign y_s = QIN_W'(quat.quat_y >>> QSH);
    assign z_s = QIN_W'(quat.quat_z >>> QSH);

    // Stage two: product sums and the clamped arcsine argument.
    always_comb
    begin
        s2_side_next.roll_y = (SUM_W'(wx_reg) + SUM_W'(yz_reg)) <<< 1;
        s2_side_next.roll_x = SUM_W'(ww_reg) - SUM_W'(xx_reg) - SUM_W'(yy_reg)
                            + SUM_W'(zz_reg);
        s2_side_next.yaw_y  = (SUM_W'(wz_reg) + SUM_W'(xy_reg)) <<< 1;
        s2_side_next.yaw_x  = SUM_W'(ww_reg) + SUM_W'(xx_reg) - SUM_W'(yy_reg)
                            - SUM_W'(zz_reg);
        s_sum = (SUM_W'(xz_reg) - SUM_W'(wy_reg)) <<< 1;
        s2_side_next.clamp = 1'b0;
        if (s_sum > ONE_S)
        begin
            s_sum = ONE_S;
            s2_side_next.clamp = 1'b1;
        end
        else if (s_sum < -ONE_S)
        begin
            s_sum = -ONE_S;
            s2_side_next.clamp = 1'b1;
        end
        s_wide = WIDE_W'(s_sum);
        s2_side_next.t = T_W'((s_wide <<< T_SH_UP) >>> T_SH_DN);
    end

    // Stage three: radicand 1 - t^2 in Q60.
    assign tt = WIDE_W'(s2_side_reg.t) * WIDE_W'(s2_side_reg.t);

    always_comb
    begin
        s3_item_next.side = s2_side_reg;
        s3_item_next.rad  = SQ_W'(RAD_ONE - tt);
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        ww_reg <= w_s * w_s;
        xx_reg <= x_s * x_s;
        yy_reg <= y_s * y_s;
        zz_reg <= z_s * z_s;
        wx_reg <= w_s * x_s;
        yz_reg <= y_s * z_s;
        wz_reg <= w_s * z_s;
        xy_reg <= x_s * y_s;
        xz_reg <= x_s * z_s;
        wy_reg <= w_s * y_s;
        s2_side_reg <= s2_side_next;
        s3_item_reg <= s3_item_next;
    end

    assign push      = s3_valid_reg;
    assign item      = s3_item_reg;
    assign status.s1 = s1_valid_reg;
    assign status.s2 = s2_valid_reg;
    assign status.s3 = s3_valid_reg;

endmodule

>>> rtl/qte_queue.sv
// Short queue between the front and the back, with a registered read port.
// The back drains one beat every cycle while the queue is not empty. Depends on qte_pkg.
module qte_queue
    import qte_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  qte_item_t         wr_item,
    output logic [QCNT_W-1:0] count,
    output logic              rd_valid,
    output qte_item_t         rd_item
);

    qte_item_t         mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              rd_valid_reg;
    qte_item_t         rd_item_reg;
    logic              pop;

    assign pop = (count_reg != '0);

    // Pointers, fill count and read strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg    <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
            rd_valid_reg <= pop;
        end
    end

    // Storage and registered read.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
        rd_item_reg <= mem[rd_ptr_reg];
    end

    assign count    = count_reg;
    assign rd_valid = rd_valid_reg;
    assign rd_item  = rd_item_reg;

endmodule

>>> rtl/qte_sqrt.sv
// Pipelined integer square root, one result bit per stage, carrying side operands.
// Depends on qte_pkg.
module qte_sqrt
    import qte_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  qte_item_t         in_item,
    output logic              out_valid,
    output qte_side_t         out_side,
    output logic [ROOT_W-1:0] root
);

    logic [SQ_W-1:0] n_reg    [SQRT_STEPS];
    logic [SQ_W-1:0] r_reg    [SQRT_STEPS];
    qte_side_t       side_reg [SQRT_STEPS];
    logic            valid_reg [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
        logic [SQ_W-1:0] n_in, r_in, trial, n_next, r_next;
        qte_side_t       side_in;
        logic            valid_in;

        if (k == 0)
        begin : g_first
            assign n_in     = in_item.rad;
            assign r_in     = '0;
            assign side_in  = in_item.side;
            assign valid_in = in_valid;
        end
        else
        begin : g_rest
            assign n_in     = n_reg[k-1];
            assign r_in     = r_reg[k-1];
            assign side_in  = side_reg[k-1];
            assign valid_in = valid_reg[k-1];
        end

        // Try the next root bit.
        always_comb
        begin
            trial = r_in + BIT;
            if (n_in >= trial)
            begin
                n_next = n_in - trial;
                r_next = (r_in >> 1) + BIT;
            end
            else
            begin
                n_next = n_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            n_reg[k]    <= n_next;
            r_reg[k]    <= r_next;
            side_reg[k] <= side_in;
        end
    end

    assign out_valid = valid_reg[SQRT_STEPS-1];
    assign out_side  = side_reg[SQRT_STEPS-1];
    assign root      = ROOT_W'(r_reg[SQRT_STEPS-1]);

endmodule

>>> rtl/qte_atan2.sv
// Pipelined two-argument arctangent: normalize, 30 CORDIC vectoring stages, quadrant fixup.
// Angle units put pi at 2^31. Depends on qte_pkg.
module qte_atan2
    import qte_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [OP_W-1:0] y_in,
    input  logic signed [OP_W-1:0] x_in,
    output logic                 out_valid,
    output logic signed [ZW-1:0] angle
);

    localparam logic signed [ZW-1:0] PI_Z      = ZW'(1) <<< 31;
    localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(1) <<< 30;

    typedef struct packed {
        logic y_zero;
        logic x_zero;
        logic y_neg;
        logic x_neg;
    } flags_t;

    logic [OP_W-1:0]  ax, ay, m;
    logic [POS_W-1:0] pos;
    flags_t           a_flags;

    logic [OP_W-1:0]  a_ax_reg, a_ay_reg;
    logic [POS_W-1:0] a_pos_reg;
    flags_t           a_flags_reg;
    logic             a_valid_reg;

    logic [OP_W-1:0]  nx, ny;

    logic signed [CW-1:0] xs_reg    [CORDIC_STEPS+1];
    logic signed [CW-1:0] ys_reg    [CORDIC_STEPS+1];
    logic signed [ZW-1:0] z_reg     [CORDIC_STEPS+1];
    flags_t               flags_reg [CORDIC_STEPS+1];
    logic                 valid_reg [CORDIC_STEPS+1];

    logic signed [ZW-1:0] z_last, z_fix;
    logic signed [ZW-1:0] angle_reg;
    logic                 out_valid_reg;

    // Magnitudes, signs and the leading one of the larger magnitude.
    always_comb
    begin
        ax = x_in[OP_W-1] ? OP_W'(-x_in) : OP_W'(x_in);
        ay = y_in[OP_W-1] ? OP_W'(-y_in) : OP_W'(y_in);
        m  = (ax > ay) ? ax : ay;
        pos = '0;
        for (int i = 0; i < OP_W; i++)
        begin
            if (m[i])
            begin
                pos = POS_W'(i);
            end
        end
        a_flags.y_zero = (y_in == '0);
        a_flags.x_zero = (x_in == '0);
        a_flags.y_neg  = y_in[OP_W-1];
        a_flags.x_neg  = x_in[OP_W-1];
    end

    // Shift the magnitudes so the larger has its leading one at NORM_MSB.
    always_comb
    begin
        if (a_pos_reg > POS_W'(NORM_MSB))
        begin
            nx = a_ax_reg >> (a_pos_reg - POS_W'(NORM_MSB));
            ny = a_ay_reg >> (a_pos_reg - POS_W'(NORM_MSB));
        end
        else
        begin
            nx = a_ax_reg << (POS_W'(NORM_MSB) - a_pos_reg);
            ny = a_ay_reg << (POS_W'(NORM_MSB) - a_pos_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            a_valid_reg  <= in_valid;
            valid_reg[0] <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_ax_reg     <= ax;
        a_ay_reg     <= ay;
        a_pos_reg    <= pos;
        a_flags_reg  <= a_flags;
        xs_reg[0]    <= CW'(nx);
        ys_reg[0]    <= CW'(ny);
        z_reg[0]     <= '0;
        flags_reg[0] <= a_flags_reg;
    end

    // CORDIC vectoring stages, one rotation each.
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        localparam logic [ZW-1:0] ATAN_I = ZW'(ATAN_TABLE[i]);
        logic signed [CW-1:0] dx, dy;

        assign dx = ys_reg[i] >>> i;
        assign dy = xs_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (!ys_reg[i][CW-1])
            begin
                xs_reg[i+1] <= xs_reg[i] + dx;
                ys_reg[i+1] <= ys_reg[i] - dy;
                z_reg[i+1]  <= z_reg[i] + ATAN_I;
            end
            else
            begin
                xs_reg[i+1] <= xs_reg[i] - dx;
                ys_reg[i+1] <= ys_reg[i] + dy;
                z_reg[i+1]  <= z_reg[i] - ATAN_I;
            end
            flags_reg[i+1] <= flags_reg[i];
        end
    end

    // Axis cases and quadrant fixup.
    always_comb
    begin
        z_last = z_reg[CORDIC_STEPS];
        if (flags_reg[CORDIC_STEPS].y_zero)
        begin
            z_fix = flags_reg[CORDIC_STEPS].x_neg ? PI_Z : '0;
        end
        else if (flags_reg[CORDIC_STEPS].x_zero)
        begin
            z_fix = flags_reg[CORDIC_STEPS].y_neg ? -HALF_PI_Z : HALF_PI_Z;
        end
        else
        begin
            z_fix = flags_reg[CORDIC_STEPS].x_neg ? (PI_Z - z_last) : z_last;
            if (flags_reg[CORDIC_STEPS].y_neg)
            begin
                z_fix = -z_fix;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= valid_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= z_fix;
    end

    assign out_valid = out_valid_reg;
    assign angle     = angle_reg;

endmodule

>>> rtl/qte_back.sv
// Back end: square root for the pitch cosine, three arctangent pipelines, output rounding.
// Depends on qte_pkg, qte_sqrt and qte_atan2.
module qte_back
    import qte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  qte_item_t  in_item,
    output logic       done,
    output euler_out_t euler
);

    localparam int ANG_SH   = 32 - ANGLE_WIDTH;
    localparam int RW       = ZW + 2;
    localparam logic signed [RW-1:0] ANG_HALF = RW'((64'(1) << ANG_SH) >> 1);

    logic              sq_valid;
    qte_side_t         sq_side;
    logic [ROOT_W-1:0] sq_root;

    logic                 roll_valid, pitch_valid, yaw_valid;
    logic signed [ZW-1:0] roll_z, pitch_z, yaw_z;

    logic       clamp_reg [ATAN_LAT];
    logic       done_reg;
    euler_out_t euler_reg, euler_next;

    // Round an angle with pi at 2^31 down to the output width, optionally negated.
    function automatic logic [ANGLE_WIDTH-1:0] round_angle(
        input logic signed [ZW-1:0] z,
        input logic                 neg
    );
        logic signed [RW-1:0] v;
        begin
            v = RW'(z);
            if (neg)
            begin
                v = -v;
            end
            v = (v + ANG_HALF) >>> ANG_SH;
            return v[ANGLE_WIDTH-1:0];
        end
    endfunction

    qte_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .root      (sq_root)
    );

    qte_atan2 u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .y_in      (OP_W'(sq_side.roll_y)),
        .x_in      (OP_W'(sq_side.roll_x)),
        .out_valid (roll_valid),
        .angle     (roll_z)
    );

    qte_atan2 u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .y_in      (OP_W'(sq_side.t)),
        .x_in      (OP_W'(sq_root)),
        .out_valid (pitch_valid),
        .angle     (pitch_z)
    );

    qte_atan2 u_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .y_in      (OP_W'(sq_side.yaw_y)),
        .x_in      (OP_W'(sq_side.yaw_x)),
        .out_valid (yaw_valid),
        .angle     (yaw_z)
    );

    // The clamp flag follows the arctangent latency.
    always_ff @(posedge clk)
    begin
        clamp_reg[0] <= sq_side.clamp;
        for (int i = 1; i < ATAN_LAT; i++)
        begin
            clamp_reg[i] <= clamp_reg[i-1];
        end
    end

    always_comb
    begin
        euler_next.roll_angle    = round_angle(roll_z, 1'b0);
        euler_next.pitch_angle   = round_angle(pitch_z, 1'b1);
        euler_next.yaw_angle     = round_angle(yaw_z, 1'b0);
        euler_next.pitch_clamped = clamp_reg[ATAN_LAT-1];
    end

    // Result register and strobe; all three units run in lockstep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= pitch_valid & roll_valid & yaw_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        euler_reg <= euler_next;
    end

    assign done  = done_reg;
    assign euler = euler_reg;

endmodule

>>> bench/tb.sv
// Self-checking bench for quaternion_to_euler: a bit-exact angle predictor checks every result.
// Depends on qte_pkg for the beat types and the arctangent table, and on the RTL top level.
module tb;
    import qte_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    quat_in_t   quat;
    logic       done;
    euler_out_t euler;

    quat_in_t   pending_quats[$];
    euler_out_t expected_angles[$];
    int         n_errors;
    int         n_sent;
    int         idle_pct;
    int         cycle_count;

    quaternion_to_euler i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .quat  (quat),
        .done  (done),
        .euler (euler)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Integer square root, bit by bit.
    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Vectoring CORDIC arctangent in units where pi is 2^31.
    function automatic longint bam_atan2(longint y, longint x);
        longint unsigned ax, ay, m;
        longint xs, ys, z, dx, dy;
        z = 0;
        if (y == 0)
            return (x < 0) ? (64'sd1 <<< 31) : 0;
        if (x == 0)
            return (y > 0) ? (64'sd1 <<< 30) : -(64'sd1 <<< 30);
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        m  = (ax > ay) ? ax : ay;
        while (m >= (64'd1 << 40))
        begin
            ax = ax >> 1; ay = ay >> 1; m = m >> 1;
        end
        while (m < (64'd1 << 39))
        begin
            ax = ax << 1; ay = ay << 1; m = m << 1;
        end
        xs = ax;
        ys = ay;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = ys >>> i;
            dy = xs >>> i;
            if (ys >= 0)
            begin
                xs = xs + dx; ys = ys - dy; z = z + longint'(ATAN_TABLE[i]);
            end
            else
            begin
                xs = xs - dx; ys = ys + dy; z = z - longint'(ATAN_TABLE[i]);
            end
        end
        if (x < 0)
            z = (64'sd1 <<< 31) - z;
        if (y < 0)
            z = -z;
        return z;
    endfunction

    // Round half up from 2^31-per-pi units down to the output angle width.
    function automatic logic [ANGLE_WIDTH-1:0] round_angle(longint z);
        longint r;
        r = (z + (64'sd1 <<< (31 - ANGLE_WIDTH))) >>> (32 - ANGLE_WIDTH);
        return r[ANGLE_WIDTH-1:0];
    endfunction

    // Euler angles of one quaternion, applied without normalization.
    function automatic euler_out_t euler_of(quat_in_t q);
        euler_out_t e;
        longint w, x, y, z, s, t, one;
        longint unsigned c;
        w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
        one = 64'sd1 <<< (2 * (QUAT_WIDTH - 2));
        e.roll_angle = round_angle(bam_atan2(2 * (w * x + y * z), w*w - x*x - y*y + z*z));
        e.yaw_angle  = round_angle(bam_atan2(2 * (w * z + x * y), w*w + x*x - y*y - z*z));
        s = 2 * (x * z - w * y);
        e.pitch_clamped = 1'b0;
        if (s > one)
        begin
            s = one; e.pitch_clamped = 1'b1;
        end
        else if (s < -one)
        begin
            s = -one; e.pitch_clamped = 1'b1;
        end
        t = s <<< (30 - 2 * (QUAT_WIDTH - 2));
        c = root64((64'd1 << 60) - t * t);
        e.pitch_angle = round_angle(-bam_atan2(t, longint'(c)));
        return e;
    endfunction

    function automatic quat_in_t mk(int w, int x, int y, int z);
        quat_in_t q;
        q.quat_w = QUAT_WIDTH'(w);
        q.quat_x = QUAT_WIDTH'(x);
        q.quat_y = QUAT_WIDTH'(y);
        q.quat_z = QUAT_WIDTH'(z);
        return q;
    endfunction

    // Driver: one beat is accepted when start is high and busy is low.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            quat  <= '0;
        end
        else if (!start || !busy)
        begin
            if (start)
            begin
                expected_angles.push_back(euler_of(quat));
                n_sent = n_sent + 1;
            end
            if (pending_quats.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                quat  <= pending_quats.pop_front();
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: every done strobe is one result beat.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_angles.size() == 0)
            begin
                $display("%0t: result with none expected, actual %h", $time, euler);
                n_errors = n_errors + 1;
            end
            else
            begin
                euler_out_t e;
                e = expected_angles.pop_front();
                if (euler.roll_angle !== e.roll_angle)
                    $display("%0t: roll expected %0d actual %0d", $time,
                             e.roll_angle, euler.roll_angle);
                if (euler.pitch_angle !== e.pitch_angle)
                    $display("%0t: pitch expected %0d actual %0d", $time,
                             e.pitch_angle, euler.pitch_angle);
                if (euler.yaw_angle !== e.yaw_angle)
                    $display("%0t: yaw expected %0d actual %0d", $time,
                             e.yaw_angle, euler.yaw_angle);
                if (euler.pitch_clamped !== e.pitch_clamped)
                    $display("%0t: clamp expected %0b actual %0b", $time,
                             e.pitch_clamped, euler.pitch_clamped);
                if (euler !== e)
                    n_errors = n_errors + 1;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 300000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Stimulus, phases and end of run.
    initial
    begin
        int phase_len;
        idle_pct    = 0;
        rst_n       = 1'b0;

        // Directed: zero, identity, extremes, axis cases, pi wrap, clamping, gimbal lock.
        pending_quats.push_back(mk(0, 0, 0, 0));
        pending_quats.push_back(mk(16384, 0, 0, 0));
        pending_quats.push_back(mk(-16384, 0, 0, 0));
        pending_quats.push_back(mk(0, 16384, 0, 0));
        pending_quats.push_back(mk(0, 0, 16384, 0));
        pending_quats.push_back(mk(0, 0, 0, 16384));
        pending_quats.push_back(mk(32767, 32767, 32767, 32767));
        pending_quats.push_back(mk(-32768, -32768, -32768, -32768));
        pending_quats.push_back(mk(32767, -32768, 32767, -32768));
        pending_quats.push_back(mk(-32768, 32767, 32767, -32768));
        pending_quats.push_back(mk(11585, 0, 11585, 0));
        pending_quats.push_back(mk(11585, 0, -11585, 0));
        pending_quats.push_back(mk(11586, 0, 11586, 0));
        pending_quats.push_back(mk(11585, 11585, 0, 0));
        pending_quats.push_back(mk(11585, 0, 0, -11585));
        pending_quats.push_back(mk(0, 32767, 0, 32767));
        pending_quats.push_back(mk(1, 0, 0, 0));
        pending_quats.push_back(mk(0, -1, 0, 0));
        pending_quats.push_back(mk(16384, 1, -1, 1));
        pending_quats.push_back(mk(-32768, 0, 32767, 0));

        // Random: mostly components in [-16384, 16383], the rest full range.
        for (int i = 0; i < 900; i++)
        begin
            if ($urandom_range(99) < 60)
                pending_quats.push_back(mk($urandom_range(32767) - 16384,
                                           $urandom_range(32767) - 16384,
                                           $urandom_range(32767) - 16384,
                                           $urandom_range(32767) - 16384));
            else
                pending_quats.push_back(quat_in_t'({$urandom, $urandom}));
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Idling phases: none, heavy sender gaps, none, light sender gaps.
        phase_len = pending_quats.size() / 4;
        wait (n_sent >= phase_len);
        idle_pct = 83;
        wait (n_sent >= 2 * phase_len);
        idle_pct = 0;
        wait (n_sent >= 3 * phase_len);
        idle_pct = 20;

        // Run until every beat has been sent and checked.
        while (pending_quats.size() != 0 || start || expected_angles.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

>>> sim.f
rtl/qte_pkg.sv
rtl/qte_front.sv
rtl/qte_queue.sv
rtl/qte_sqrt.sv
rtl/qte_atan2.sv
rtl/qte_back.sv
rtl/quaternion_to_euler.sv
bench/tb.sv
